// ===== rtl/bte_pkg.sv =====
// Shared constants and types of the Bezier trajectory evaluator.
`default_nettype none

package bte_pkg;

    localparam int TFRAC  = 24;
    localparam int WORK_W = 40;
    localparam int MAG_W  = 44;
    localparam int NUM_W  = 64;
    localparam int DUR_W  = 20;
    localparam int FAC_W  = 20;
    localparam int TPS_W  = 16;
    localparam int SUSE_W = 5;
    localparam int AXES   = 4;

    typedef logic signed [31:0]       t_fixed;
    typedef logic signed [WORK_W-1:0] t_work;

    localparam logic [1:0] FUNC_POINT    = 2'd0;
    localparam logic [1:0] FUNC_DURATION = 2'd1;
    localparam logic [1:0] FUNC_START    = 2'd2;
    localparam logic [1:0] FUNC_TICK     = 2'd3;

    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_SEGMENTS  = 2'd1;
    localparam logic [1:0] REG_TICK_RATE = 2'd2;

    localparam logic [2:0] ORDER_ACCEL = 3'd2;
    localparam logic [2:0] ORDER_JERK  = 3'd3;
    localparam logic [2:0] ORDER_SNAP  = 3'd4;

    localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << (MAG_W - 1);

endpackage

`default_nettype wire

// ===== rtl/bte_intf.sv =====
// Handshake channel interfaces of the Bezier trajectory evaluator.
`default_nettype none

interface bte_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [3:0]         segment;
    logic [3:0]         point;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] z_value;
    logic signed [31:0] yaw_value;
    logic [19:0]        duration_ticks;
    logic [31:0]        tick;
    modport source (output valid, func, segment, point, x_value, y_value, z_value,
                    yaw_value, duration_ticks, tick, input ready);
    modport sink (input valid, func, segment, point, x_value, y_value, z_value,
                  yaw_value, duration_ticks, tick, output ready);
endinterface

interface bte_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         order;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic signed [31:0] yaw_out;
    logic               last;
    modport source (output valid, order, x_out, y_out, z_out, yaw_out, last, input ready);
    modport sink (input valid, order, x_out, y_out, z_out, yaw_out, last, output ready);
endinterface

interface bte_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bezier_trajectory_evaluator.sv =====
// Top level of the Bezier trajectory evaluator: sequencer and shared datapath.
//
// Input channel i_in takes one word per item: control point writes, segment
// duration writes, a start mark and ticks. A tick always updates the segment
// position; in evaluate mode it then produces five words on o_out (position,
// velocity, acceleration, jerk, snap), the snap word flagged with last. The
// tick is worked per axis and order through one shared subtract/multiply unit
// and one bit-serial divider. Per axis the sequencer loads the control points,
// forms the differences for the order, runs the de Casteljau passes and, for a
// derivative, scales the result through the divider; i_in is not ready while
// a tick is worked in evaluate mode. o_out has an output register: a stalled
// receiver holds the sequencer only when the next word is done, and a new item
// is taken while the final word still waits. Configuration on i_cfg is always
// ready; it is to be written only while the block is idle, which the block
// itself does not enforce. Reset selects segment 0, clears the start tick and
// the sequencer registers, and sets mode 0, 15 segments and tick rate 1000;
// point and duration stores hold nothing valid until written.
`default_nettype none

module bezier_trajectory_evaluator #(
    parameter int MAX_SEGMENTS = 16,
    parameter int CURVE_DEGREE = 9
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bte_in_if.sink     i_in,
    bte_cfg_if.sink    i_cfg,
    bte_out_if.source  o_out
);
    import bte_pkg::*;

    localparam int NPTS  = CURVE_DEGREE + 1;
    localparam int SW    = MAX_SEGMENTS > 1 ? $clog2(MAX_SEGMENTS) : 1;
    localparam int DEPTH = MAX_SEGMENTS * NPTS;
    localparam int CW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(NPTS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DUR    = 4'd1;
    localparam logic [3:0] S_TSTART = 4'd2;
    localparam logic [3:0] S_TDIV   = 4'd3;
    localparam logic [3:0] S_LOAD   = 4'd4;
    localparam logic [3:0] S_DIFF   = 4'd5;
    localparam logic [3:0] S_CAST   = 4'd6;
    localparam logic [3:0] S_ABS    = 4'd7;
    localparam logic [3:0] S_FAC    = 4'd8;
    localparam logic [3:0] S_MLO    = 4'd9;
    localparam logic [3:0] S_MHI    = 4'd10;
    localparam logic [3:0] S_DSTART = 4'd11;
    localparam logic [3:0] S_DWAIT  = 4'd12;
    localparam logic [3:0] S_SAT    = 4'd13;
    localparam logic [3:0] S_EMIT   = 4'd14;

    // Control state.
    logic [3:0]        r_state;
    logic              r_mode;
    logic [SUSE_W-1:0] r_used;
    logic [TPS_W-1:0]  r_tps;
    logic [SW-1:0]     r_cur;
    logic [31:0]       r_start;
    logic [2:0]        r_k;
    logic [1:0]        r_axis;
    logic [PW-1:0]     r_pass;
    logic [PW-1:0]     r_step;
    logic [PW-1:0]     r_ldi;
    logic              r_phase;
    logic [2:0]        r_j;
    logic              r_ov;

    // Datapath.
    logic [DUR_W-1:0]    r_durs [MAX_SEGMENTS];
    logic [DUR_W-1:0]    r_dur;
    logic [DUR_W-1:0]    r_elapsed;
    logic [TFRAC-1:0]    r_t;
    t_work               r_d [NPTS];
    logic signed [63:0]  r_prod;
    logic                r_neg;
    logic [MAG_W-1:0]    r_mag;
    logic [FAC_W-1:0]    r_fac;
    logic [NUM_W-1:0]    r_acc;
    logic [41:0]         r_hi;
    t_fixed              r_res [AXES];
    logic [2:0]          r_order;
    t_fixed              r_x, r_y, r_z, r_yaw;
    logic                r_last;

    // Combinational next values.
    logic              n_accept;
    logic [31:0]       n_elapsed32;
    logic [DUR_W-1:0]  n_dur_cur;
    logic [DUR_W-1:0]  n_dur_eff;
    logic              n_over;
    logic [6:0]        n_used;
    logic [6:0]        n_cur_inc;
    logic [SW-1:0]     n_next_cur;
    logic [SW+3:0]     n_seg_ext;
    logic              n_seg_ok;
    logic              n_pt_we;
    logic [CW-1:0]     n_waddr;
    logic [CW-1:0]     n_raddr;
    logic [PW-1:0]     n_ld_ofs;
    logic [31:0]       n_rdata [AXES];
    logic [31:0]       n_wdata [AXES];
    t_fixed            n_pt;
    logic signed [WORK_W:0]   n_dd;
    logic signed [65:0]       n_mul;
    logic signed [63:0]       n_sum;
    t_work             n_round;
    logic [PW-1:0]     n_diff_cnt;
    logic [PW-1:0]     n_cast_cnt;
    logic [PW-1:0]     n_cast_last;
    logic              n_push;
    t_work             n_push_val;
    logic [3:0]        n_nj;
    logic [FAC_W-1:0]  n_fac;
    logic [21:0]       n_mop;
    logic [41:0]       n_mprod;
    logic              n_div_start;
    logic [NUM_W-1:0]  n_div_num;
    logic              n_div_done;
    logic [NUM_W-1:0]  n_quot;
    logic [1:0]        n_last_axis;
    t_fixed            n_sat;
    logic              n_out_free;
    logic              n_ov_load;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign n_accept    = i_in.valid && (r_state == S_IDLE);

    // Segment position bookkeeping for tick items.
    assign n_elapsed32 = i_in.tick - r_start;
    assign n_dur_cur   = r_durs[r_cur];
    assign n_dur_eff   = (n_dur_cur == '0) ? DUR_W'(1) : n_dur_cur;
    assign n_over      = n_elapsed32 >= 32'(n_dur_eff);
    always_comb begin
        if (r_used == '0) begin
            n_used = 7'd1;
        end else if (32'(r_used) > MAX_SEGMENTS) begin
            n_used = 7'(MAX_SEGMENTS);
        end else begin
            n_used = 7'(r_used);
        end
    end
    assign n_cur_inc  = 7'(r_cur) + 7'd1;
    assign n_next_cur = (n_cur_inc >= n_used) ? '0 : n_cur_inc[SW-1:0];

    // Control point store, one RAM per axis.
    assign n_seg_ext = {{SW{1'b0}}, i_in.segment};
    assign n_seg_ok  = 32'(i_in.segment) < MAX_SEGMENTS;
    assign n_pt_we   = n_accept && (i_in.func == FUNC_POINT) && n_seg_ok
                       && (32'(i_in.point) < NPTS);
    assign n_waddr   = CW'(n_seg_ext[SW-1:0]) * CW'(NPTS) + CW'(i_in.point);
    assign n_ld_ofs  = (r_ldi == PW'(NPTS)) ? '0 : r_ldi;
    assign n_raddr   = CW'(r_cur) * CW'(NPTS) + CW'(n_ld_ofs);
    assign n_wdata[0] = i_in.x_value;
    assign n_wdata[1] = i_in.y_value;
    assign n_wdata[2] = i_in.z_value;
    assign n_wdata[3] = i_in.yaw_value;

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        bte_ram #(
            .WIDTH (32),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (n_pt_we),
            .i_waddr (n_waddr),
            .i_wdata (n_wdata[g]),
            .i_raddr (n_raddr),
            .o_rdata (n_rdata[g])
        );
    end

    assign n_pt = n_rdata[r_axis];

    // Shared difference / blend unit. The blend a*s + b*t is a*2^24 + (b-a)*t.
    assign n_dd    = (WORK_W + 1)'(r_d[1]) - (WORK_W + 1)'(r_d[0]);
    assign n_mul   = n_dd * $signed({1'b0, r_t});
    assign n_sum   = (64'(r_d[0]) <<< TFRAC) + r_prod + (64'sd1 <<< (TFRAC - 1));
    assign n_round = WORK_W'(n_sum >>> TFRAC);

    assign n_diff_cnt  = PW'(CURVE_DEGREE) - r_pass;
    assign n_cast_cnt  = PW'(CURVE_DEGREE) - PW'(r_k) - r_pass;
    assign n_cast_last = PW'(CURVE_DEGREE) - PW'(r_k) - PW'(1);

    always_comb begin
        n_push     = 1'b0;
        n_push_val = r_d[0];
        case (r_state)
            S_LOAD: begin
                n_push     = (r_ldi != '0);
                n_push_val = WORK_W'(n_pt);
            end
            S_DIFF: begin
                n_push     = 1'b1;
                n_push_val = (r_step < n_diff_cnt) ? WORK_W'(n_dd) : r_d[0];
            end
            S_CAST: begin
                n_push     = r_phase;
                n_push_val = (r_step < n_cast_cnt) ? n_round : r_d[0];
            end
            default: begin
                n_push     = 1'b0;
                n_push_val = r_d[0];
            end
        endcase
    end

    // Each pass rotates the whole row once, so results land back in place.
    always_ff @(posedge i_clk) begin
        if (n_push) begin
            for (int i = 0; i < NPTS - 1; i++) begin
                r_d[i] <= r_d[i + 1];
            end
            r_d[NPTS-1] <= n_push_val;
        end
    end

    // Derivative scaling: magnitude times (n-j)*rate, split into two halves.
    assign n_nj    = 4'(CURVE_DEGREE) - 4'(r_j);
    assign n_fac   = n_nj * r_tps;
    assign n_mop   = (r_state == S_MLO) ? r_mag[21:0] : r_mag[43:22];
    assign n_mprod = n_mop * r_fac;

    assign n_div_start = (r_state == S_TSTART) || (r_state == S_DSTART);
    assign n_div_num   = (r_state == S_TSTART)
                         ? NUM_W'({r_elapsed, {TFRAC{1'b0}}})
                         : r_acc + {r_hi, 22'b0} + NUM_W'(r_dur >> 1);

    bte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_num   (n_div_num),
        .i_den   (r_dur),
        .o_done  (n_div_done),
        .o_quot  (n_quot)
    );

    assign n_last_axis = (r_k <= ORDER_ACCEL) ? 2'd3 : 2'd2;

    always_comb begin
        if (r_neg) begin
            n_sat = (r_mag > (MAG_W'(1) << 31)) ? 32'sh8000_0000
                                                : t_fixed'(32'd0 - r_mag[31:0]);
        end else begin
            n_sat = (r_mag > MAG_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                    : t_fixed'(r_mag[31:0]);
        end
    end

    assign n_out_free = !r_ov || o_out.ready;
    assign n_ov_load  = (r_state == S_EMIT) && n_out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_used <= SUSE_W'(15);
            r_tps  <= TPS_W'(1000);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MODE:      r_mode <= i_cfg.data[0];
                REG_SEGMENTS:  r_used <= i_cfg.data[SUSE_W-1:0];
                REG_TICK_RATE: r_tps  <= i_cfg.data[TPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept && (i_in.func == FUNC_DURATION) && n_seg_ok) begin
            r_durs[n_seg_ext[SW-1:0]] <= i_in.duration_ticks;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            r_start <= '0;
            r_k     <= '0;
            r_axis  <= '0;
            r_pass  <= '0;
            r_step  <= '0;
            r_ldi   <= '0;
            r_phase <= 1'b0;
            r_j     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= n_ov_load || (r_ov && !o_out.ready);
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        case (i_in.func)
                            FUNC_START: begin
                                r_start <= i_in.tick;
                                r_cur   <= '0;
                            end
                            FUNC_TICK: begin
                                if (n_over) begin
                                    r_cur     <= n_next_cur;
                                    r_start   <= i_in.tick;
                                    r_elapsed <= '0;
                                end else begin
                                    r_elapsed <= n_elapsed32[DUR_W-1:0];
                                end
                                if (r_mode) begin
                                    r_state <= S_DUR;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DUR: begin
                    r_dur   <= n_dur_eff;
                    r_state <= S_TSTART;
                end
                S_TSTART: begin
                    r_state <= S_TDIV;
                end
                S_TDIV: begin
                    if (n_div_done) begin
                        r_t     <= n_quot[TFRAC-1:0];
                        r_k     <= '0;
                        r_axis  <= '0;
                        r_ldi   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_ldi == PW'(NPTS)) begin
                        r_pass  <= '0;
                        r_step  <= '0;
                        r_phase <= 1'b0;
                        r_state <= (r_k == '0) ? S_CAST : S_DIFF;
                    end else begin
                        r_ldi <= r_ldi + 1'b1;
                    end
                end
                S_DIFF: begin
                    if (r_step == PW'(NPTS - 1)) begin
                        r_step <= '0;
                        if (r_pass == PW'(r_k) - PW'(1)) begin
                            r_pass  <= '0;
                            r_state <= S_CAST;
                        end else begin
                            r_pass <= r_pass + 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_CAST: begin
                    r_phase <= !r_phase;
                    if (!r_phase) begin
                        r_prod <= n_mul[63:0];
                    end else if (r_step == PW'(NPTS - 1)) begin
                        r_step <= '0;
                        if (r_pass == n_cast_last) begin
                            r_state <= S_ABS;
                        end else begin
                            r_pass <= r_pass + 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_ABS: begin
                    r_neg   <= r_d[0] < 0;
                    r_mag   <= MAG_W'((r_d[0] < 0) ? -r_d[0] : r_d[0]);
                    r_j     <= '0;
                    r_state <= (r_k == '0) ? S_SAT : S_FAC;
                end
                S_FAC: begin
                    r_fac   <= n_fac;
                    r_state <= S_MLO;
                end
                S_MLO: begin
                    r_acc   <= NUM_W'(n_mprod);
                    r_state <= S_MHI;
                end
                S_MHI: begin
                    r_hi    <= n_mprod;
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (n_div_done) begin
                        r_mag <= (n_quot > NUM_W'(MAG_CAP)) ? MAG_CAP : n_quot[MAG_W-1:0];
                        if (r_j + 3'd1 == r_k) begin
                            r_state <= S_SAT;
                        end else begin
                            r_j     <= r_j + 3'd1;
                            r_state <= S_FAC;
                        end
                    end
                end
                S_SAT: begin
                    r_res[r_axis] <= n_sat;
                    if (r_axis == n_last_axis) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_ldi   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_EMIT: begin
                    if (n_out_free) begin
                        r_order <= r_k;
                        r_x     <= r_res[0];
                        r_y     <= r_res[1];
                        r_z     <= r_res[2];
                        r_yaw   <= (r_k <= ORDER_ACCEL) ? r_res[3] : '0;
                        r_last  <= (r_k == ORDER_SNAP);
                        if (r_k == ORDER_SNAP) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_axis  <= '0;
                            r_ldi   <= '0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid   = r_ov;
    assign o_out.order   = r_order;
    assign o_out.x_out   = r_x;
    assign o_out.y_out   = r_y;
    assign o_out.z_out   = r_z;
    assign o_out.yaw_out = r_yaw;
    assign o_out.last    = r_last;

`ifndef ASSERT_OFF
    a_last_is_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last == (o_out.order == ORDER_SNAP)))
        else $error("last flag does not match the snap word");

    a_yaw_zero_high_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.order == ORDER_JERK || o_out.order == ORDER_SNAP))
        |-> (o_out.yaw_out == '0))
        else $error("yaw must be zero for jerk and snap");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.func == FUNC_TICK) && r_mode)
        |=> !i_in.ready)
        else $error("evaluating tick did not hold off the input");
`endif

endmodule

`default_nettype wire

// ===== rtl/bte_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module bte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 160
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/bte_div.sv =====
// Restoring divider, one quotient bit per cycle, for the evaluator.
`default_nettype none

module bte_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bte_pkg::NUM_W-1:0]  i_num,
    input  wire logic [bte_pkg::DUR_W-1:0]  i_den,
    output logic                            o_done,
    output logic [bte_pkg::NUM_W-1:0]       o_quot
);
    import bte_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DUR_W-1:0] r_rem;
    logic [DUR_W-1:0] r_den;
    logic [DUR_W:0]   n_rem_sh;
    logic             n_ge;

    assign n_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign n_ge     = n_rem_sh >= {1'b0, r_den};
    assign o_quot   = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], n_ge};
            r_rem <= n_ge ? DUR_W'(n_rem_sh - {1'b0, r_den}) : n_rem_sh[DUR_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the Bezier trajectory evaluator with a built-in trajectory predictor.
`default_nettype none

module testbench;
    import bte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSEG   = 16;
    localparam int NPT    = 10;
    localparam int DEG    = 9;
    localparam int LIMIT  = 4_000_000;
    localparam int HOLD   = 20_000;
    localparam int NROWS  = 21;

    typedef struct {
        logic [1:0]  func;
        logic [3:0]  segment;
        logic [3:0]  point;
        logic [31:0] x, y, z, yaw;
        logic [19:0] duration;
        logic [31:0] tick;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  order;
        logic [31:0] x, y, z, yaw;
        logic        last;
    } t_motion_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bte_in_if  in_ch ();
    bte_cfg_if cfg_ch ();
    bte_out_if out_ch ();

    bezier_trajectory_evaluator dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state.
    logic [31:0] ctrl_pts [NSEG][NPT][AXES];
    logic [19:0] seg_len [NSEG];
    int unsigned cur_seg;
    logic [31:0] seg_start;
    logic        eval_on;
    logic [4:0]  seg_count;
    logic [15:0] tick_rate;

    t_motion_word expected_words[$];
    int unsigned  cycles = 0;
    int unsigned  mismatches = 0;
    int unsigned  words_checked = 0;
    int unsigned  items_sent = 0;
    int unsigned  eval_ticks = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    int unsigned  hold_left = 0;
    bit           hold_req = 0;

    function automatic longint unsigned span_of(int unsigned seg);
        return (seg_len[seg] == 0) ? 64'd1 : {44'd0, seg_len[seg]};
    endfunction

    // One axis, one derivative order: differences, de Casteljau, then scaling.
    function automatic logic [31:0] axis_value(int unsigned seg, int ax, int k,
                                               longint unsigned t, longint unsigned span);
        longint          pts [NPT];
        longint unsigned s;
        longint unsigned mag;
        bit              neg;
        int              m;
        s = (64'd1 << TFRAC) - t;
        m = DEG - k;
        for (int i = 0; i < NPT; i++) pts[i] = longint'($signed(ctrl_pts[seg][i][ax]));
        for (int r = 0; r < k; r++)
            for (int i = 0; i < DEG - r; i++) pts[i] = pts[i+1] - pts[i];
        for (int r = 1; r <= m; r++)
            for (int i = 0; i <= m - r; i++)
                pts[i] = (pts[i] * longint'(s) + pts[i+1] * longint'(t)
                          + (64'sd1 <<< (TFRAC - 1))) >>> TFRAC;
        neg = pts[0] < 0;
        mag = neg ? longint'(-pts[0]) : longint'(pts[0]);
        for (int j = 0; j < k; j++) begin
            mag = mag * (longint'(DEG - j) * longint'(tick_rate));
            mag = (mag + span / 2) / span;
            if (mag > (64'd1 << 43)) mag = 64'd1 << 43;
        end
        if (neg) return (mag > (64'd1 << 31)) ? 32'h8000_0000 : 32'(-longint'(mag));
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    // Updates the trajectory state for one accepted word and queues its results.
    // With fixed set, the word's value fields hold a constant curve's position.
    task automatic track_item(input t_in_word w, input bit fixed);
        logic [31:0]     elapsed;
        longint unsigned span;
        longint unsigned t;
        int unsigned     used;
        t_motion_word    r;
        case (w.func)
            FUNC_POINT: begin
                if (w.point < NPT) begin
                    ctrl_pts[w.segment][w.point][0] = w.x;
                    ctrl_pts[w.segment][w.point][1] = w.y;
                    ctrl_pts[w.segment][w.point][2] = w.z;
                    ctrl_pts[w.segment][w.point][3] = w.yaw;
                end
            end
            FUNC_DURATION: seg_len[w.segment] = w.duration;
            FUNC_START: begin
                seg_start = w.tick;
                cur_seg = 0;
            end
            default: begin
                elapsed = w.tick - seg_start;
                span = span_of(cur_seg);
                if (elapsed >= span) begin
                    used = (seg_count == 0) ? 1 : (seg_count > NSEG) ? NSEG : seg_count;
                    cur_seg = (cur_seg + 1 >= used) ? 0 : cur_seg + 1;
                    seg_start = w.tick;
                    elapsed = 0;
                    span = span_of(cur_seg);
                end
                if (eval_on) begin
                    eval_ticks++;
                    t = ({32'd0, elapsed} << TFRAC) / span;
                    for (int k = 0; k < 5; k++) begin
                        r.order = 3'(k);
                        r.last = (3'(k) == ORDER_SNAP);
                        if (fixed) begin
                            r.x = (k == 0) ? w.x : '0;
                            r.y = (k == 0) ? w.y : '0;
                            r.z = (k == 0) ? w.z : '0;
                            r.yaw = (k == 0) ? w.yaw : '0;
                        end else begin
                            r.x = axis_value(cur_seg, 0, k, t, span);
                            r.y = axis_value(cur_seg, 1, k, t, span);
                            r.z = axis_value(cur_seg, 2, k, t, span);
                            r.yaw = (3'(k) <= ORDER_ACCEL) ?
                                    axis_value(cur_seg, 3, k, t, span) : '0;
                        end
                        expected_words.push_back(r);
                    end
                end
            end
        endcase
    endtask

    task automatic send_item(input t_in_word w, input bit fixed);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.func           <= w.func;
        in_ch.segment        <= w.segment;
        in_ch.point          <= w.point;
        in_ch.x_value        <= w.x;
        in_ch.y_value        <= w.y;
        in_ch.z_value        <= w.z;
        in_ch.yaw_value      <= w.yaw;
        in_ch.duration_ticks <= w.duration;
        in_ch.tick           <= w.tick;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        track_item(w, fixed);
        items_sent++;
    endtask

    // Waits for all expected words, then lets the block settle before a register write.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_MODE:      eval_on = value[0];
            REG_SEGMENTS:  seg_count = value[4:0];
            REG_TICK_RATE: tick_rate = value;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic m, input logic [4:0] segs, input logic [15:0] rate);
        write_reg(REG_MODE, {15'd0, m});
        write_reg(REG_SEGMENTS, {11'd0, segs});
        write_reg(REG_TICK_RATE, rate);
    endtask

    function automatic t_in_word make_word(logic [1:0] f, logic [3:0] sg, logic [3:0] pt,
                                           logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                           logic [31:0] yaw, logic [19:0] d, logic [31:0] tk);
        t_in_word w;
        w.func = f; w.segment = sg; w.point = pt;
        w.x = x; w.y = y; w.z = z; w.yaw = yaw;
        w.duration = d; w.tick = tk;
        return w;
    endfunction

    function automatic logic [31:0] coord_value();
        case ($urandom_range(3))
            0: return 32'($signed($urandom_range(2047)) - 1024) <<< $urandom_range(20);
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [19:0] span_value();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 10) return 20'd0;
        if (p < 80) return 20'($urandom_range(1, 30));
        return 20'($urandom);
    endfunction

    // Mostly ticks that walk through the segments, mixed with writes and restarts.
    task automatic random_items(input int n);
        t_in_word    w;
        int unsigned p;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(99);
            w = make_word(FUNC_TICK, 4'($urandom), 4'($urandom), $urandom, $urandom,
                          $urandom, $urandom, 20'($urandom), $urandom);
            if (p < 22) begin
                w.func = FUNC_POINT;
                w.point = ($urandom_range(9) == 0) ? 4'($urandom_range(10, 15))
                                                  : 4'($urandom_range(9));
                w.x = coord_value(); w.y = coord_value();
                w.z = coord_value(); w.yaw = coord_value();
            end else if (p < 32) begin
                w.func = FUNC_DURATION;
                w.duration = span_value();
            end else if (p < 37) begin
                w.func = FUNC_START;
            end else if (p < 92) begin
                w.tick = seg_start + 32'($urandom_range(0, 32'(span_of(cur_seg)) + 2));
            end
            send_item(w, 1'b0);
        end
    endtask

    // Receiver: checks each accepted word and drives ready for the next edge.
    always @(posedge i_clk) begin
        t_motion_word got;
        t_motion_word want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.order, out_ch.x_out, out_ch.y_out, out_ch.z_out,
                       out_ch.yaw_out, out_ch.last};
                words_checked++;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: order %0d x %h y %h z %h yaw %h last %b",
                                 got.order, got.x, got.y, got.z, got.yaw, got.last);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected order %0d x %h y %h z %h yaw %h last %b, got order %0d x %h y %h z %h yaw %h last %b",
                                     want.order, want.x, want.y, want.z, want.yaw, want.last,
                                     got.order, got.x, got.y, got.z, got.yaw, got.last);
                    end
                end
            end
            if (hold_req) begin
                hold_req = 0;
                hold_left = HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    t_in_word directed [NROWS];
    bit       directed_fixed [NROWS];

    initial begin
        t_in_word w;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_POINT;
        in_ch.segment = '0;
        in_ch.point = '0;
        in_ch.x_value = '0;
        in_ch.y_value = '0;
        in_ch.z_value = '0;
        in_ch.yaw_value = '0;
        in_ch.duration_ticks = '0;
        in_ch.tick = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_MODE;
        cfg_ch.data = '0;
        cur_seg = 0;
        seg_start = '0;
        eval_on = 1'b0;
        seg_count = 5'd15;
        tick_rate = 16'd1000;

        // A flat segment at the coordinate extremes: position is the point, all
        // derivatives are zero. Covers ignored writes, zero and longest duration,
        // and elapsed wrap in both directions.
        for (int i = 0; i < NPT; i++)
            directed[i] = make_word(FUNC_POINT, 4'd0, 4'(i), 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h0, 32'hFFFF_FFFF, '0, '0);
        directed[10] = make_word(FUNC_POINT, 4'd0, 4'd15, 32'd1, 32'd2, 32'd3, 32'd4, '0, '0);
        directed[11] = make_word(FUNC_POINT, 4'd0, 4'd10, 32'd5, 32'd6, 32'd7, 32'd8, '0, '0);
        directed[12] = make_word(FUNC_DURATION, 4'd0, '0, '0, '0, '0, '0, 20'd0, '0);
        directed[13] = make_word(FUNC_START, '0, '0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF);
        directed[14] = make_word(FUNC_TICK, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF);
        directed[15] = make_word(FUNC_TICK, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                 32'hFFFF_FFFF, '0, 32'h0);
        directed[16] = make_word(FUNC_TICK, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                 32'hFFFF_FFFF, '0, 32'd12345);
        directed[17] = make_word(FUNC_DURATION, 4'd0, '0, '0, '0, '0, '0, 20'hFFFFF, '0);
        directed[18] = make_word(FUNC_START, '0, '0, '0, '0, '0, '0, '0, 32'd5);
        directed[19] = make_word(FUNC_TICK, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                 32'hFFFF_FFFF, '0, 32'd5 + 32'hFFFFF - 32'd1);
        directed[20] = make_word(FUNC_TICK, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                 32'hFFFF_FFFF, '0, 32'd4);
        for (int i = 0; i < NROWS; i++) directed_fixed[i] = (directed[i].func == FUNC_TICK);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 11;
        recv_idle_pct = 61;
        set_regs(1'b1, 5'd1, 16'hFFFF);
        for (int i = 0; i < NROWS; i++) send_item(directed[i], directed_fixed[i]);

        // Fill every segment so that any list length reads only written entries.
        for (int s = 0; s < NSEG; s++) begin
            for (int p = 0; p < NPT; p++) begin
                w = make_word(FUNC_POINT, 4'(s), 4'(p), coord_value(), coord_value(),
                              coord_value(), coord_value(), '0, '0);
                send_item(w, 1'b0);
            end
            w = make_word(FUNC_DURATION, 4'(s), '0, '0, '0, '0, '0, span_value(), '0);
            send_item(w, 1'b0);
        end

        drain();
        set_regs(1'b1, 5'd16, 16'hFFFF);
        random_items(8);

        drain();
        send_idle_pct = 61;
        recv_idle_pct = 11;
        set_regs(1'b0, 5'd0, 16'd1);
        random_items(8);

        drain();
        set_regs(1'b1, 5'd31, 16'd0);
        random_items(8);

        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(1'b1, 5'd3, 16'd1000);
        // A long receiver stall while ticks keep coming fills the output path.
        hold_req = 1;
        for (int i = 0; i < 4; i++) begin
            w = make_word(FUNC_TICK, '0, '0, '0, '0, '0, '0, '0,
                          seg_start + 32'($urandom_range(0, 3)));
            send_item(w, 1'b0);
        end
        random_items(4);

        drain();
        repeat (200) @(posedge i_clk);
        $display("Sent %0d input words, %0d of them evaluated ticks; checked %0d output words.",
                 items_sent, eval_ticks, words_checked);
        $display("Register settings covered idle mode, list lengths 0 to 31 and tick rates 0 to 65535.");
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d words still expected", mismatches,
                     expected_words.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
